### hw/rtl/istp_pkg.sv
// Shared types and constants of the IMAP string token parser.
// No dependencies.
`default_nettype none
package istp_pkg;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_TILDE     = 8'h7E;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;

  localparam logic [1:0] KIND_QUOTED   = 2'd0;
  localparam logic [1:0] KIND_LITERAL  = 2'd1;
  localparam logic [1:0] KIND_LITERAL8 = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ESCAPE = 3'd1;
  localparam logic [2:0] ST_CRLF_QUOTE = 3'd2;
  localparam logic [2:0] ST_BAD_SPEC   = 3'd3;
  localparam logic [2:0] ST_BAD_SIZE   = 3'd4;
  localparam logic [2:0] ST_NO_DATA    = 3'd5;
  localparam logic [2:0] ST_NOT_STRING = 3'd6;

  localparam logic [1:0] SPEC_CR = 2'd1;
  localparam logic [1:0] SPEC_LF = 2'd2;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       done_res;
    logic [1:0] kind;
    logic [2:0] status;
  } result_t;

endpackage
`default_nettype wire

### hw/rtl/istp_parse.sv
// Token state machine: updates the parse state per accepted byte and forms the result.
// Depends on istp_pkg.
`default_nettype none
module istp_parse #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       data_byte_i,
  input  wire logic             first_i,
  input  wire logic             last_i,
  output istp_pkg::result_t     res_o,
  output logic                  res_valid_o
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_QUOTED, PH_TILDE, PH_SIZE, PH_SPEC, PH_DATA
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   esc_q, esc_d;
  logic [SIZE_BITS-1:0]   cnt_q, cnt_d;
  logic                   digit_q, digit_d;
  logic [1:0]             spec_q, spec_d;
  logic [1:0]             kind_q, kind_d;

  logic [SIZE_BITS+3:0]   size_next;
  logic [SIZE_BITS-1:0]   cnt_dec;
  logic                   is_digit;
  logic                   done;
  logic [2:0]             status;
  logic [7:0]             ob;
  logic                   ov;

  assign is_digit  = (data_byte_i >= istp_pkg::CH_ZERO) && (data_byte_i <= istp_pkg::CH_NINE);
  // 10*n + d; any bit above SIZE_BITS means overflow
  assign size_next = ({4'b0, cnt_q} << 3) + ({4'b0, cnt_q} << 1)
                   + {{(SIZE_BITS){1'b0}}, 4'(data_byte_i - istp_pkg::CH_ZERO)};
  assign cnt_dec   = cnt_q - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    cnt_d   = cnt_q;
    digit_d = digit_q;
    spec_d  = spec_q;
    kind_d  = kind_q;
    done    = 1'b0;
    status  = istp_pkg::ST_OK;
    ob      = 8'h00;
    ov      = 1'b0;

    if (first_i) begin
      esc_d   = 1'b0;
      cnt_d   = '0;
      digit_d = 1'b0;
      spec_d  = 2'd0;
      kind_d  = istp_pkg::KIND_QUOTED;
      if (data_byte_i == istp_pkg::CH_QUOTE) begin
        phase_d = PH_QUOTED;
        if (last_i) begin done = 1'b1; status = istp_pkg::ST_NO_DATA; end
      end else if (data_byte_i == istp_pkg::CH_LBRACE) begin
        phase_d = PH_SIZE;
        kind_d  = istp_pkg::KIND_LITERAL;
        if (last_i) begin done = 1'b1; status = istp_pkg::ST_NO_DATA; end
      end else if (data_byte_i == istp_pkg::CH_TILDE) begin
        phase_d = PH_TILDE;
        kind_d  = istp_pkg::KIND_LITERAL8;
        if (last_i) begin done = 1'b1; status = istp_pkg::ST_NOT_STRING; end
      end else begin
        done = 1'b1; status = istp_pkg::ST_NOT_STRING;
      end
    end else begin
      unique case (phase_q)
        PH_QUOTED: begin
          if (esc_q) begin
            esc_d = 1'b0;
            if (data_byte_i == istp_pkg::CH_QUOTE || data_byte_i == istp_pkg::CH_BACKSLASH)
            begin
              ob = data_byte_i; ov = 1'b1;
              if (last_i) begin done = 1'b1; status = istp_pkg::ST_NO_DATA; end
            end else begin
              done = 1'b1; status = istp_pkg::ST_BAD_ESCAPE;
            end
          end else if (data_byte_i == istp_pkg::CH_QUOTE) begin
            done = 1'b1; status = istp_pkg::ST_OK;
          end else if (data_byte_i == istp_pkg::CH_CR || data_byte_i == istp_pkg::CH_LF) begin
            done = 1'b1; status = istp_pkg::ST_CRLF_QUOTE;
          end else begin
            if (data_byte_i == istp_pkg::CH_BACKSLASH) begin
              esc_d = 1'b1;
            end else begin
              ob = data_byte_i; ov = 1'b1;
            end
            if (last_i) begin done = 1'b1; status = istp_pkg::ST_NO_DATA; end
          end
        end
        PH_TILDE: begin
          if (data_byte_i == istp_pkg::CH_LBRACE) begin
            phase_d = PH_SIZE;
            if (last_i) begin done = 1'b1; status = istp_pkg::ST_NO_DATA; end
          end else begin
            done = 1'b1; status = istp_pkg::ST_NOT_STRING;
          end
        end
        PH_SIZE: begin
          if (is_digit) begin
            if (|size_next[SIZE_BITS+3:SIZE_BITS]) begin
              done = 1'b1; status = istp_pkg::ST_BAD_SIZE;
            end else begin
              cnt_d   = size_next[SIZE_BITS-1:0];
              digit_d = 1'b1;
              if (last_i) begin done = 1'b1; status = istp_pkg::ST_BAD_SPEC; end
            end
          end else if (!digit_q) begin
            done = 1'b1; status = istp_pkg::ST_BAD_SIZE;
          end else if (data_byte_i == istp_pkg::CH_RBRACE) begin
            phase_d = PH_SPEC;
            spec_d  = istp_pkg::SPEC_CR;
            if (last_i) begin done = 1'b1; status = istp_pkg::ST_BAD_SPEC; end
          end else begin
            done = 1'b1; status = istp_pkg::ST_BAD_SPEC;
          end
        end
        PH_SPEC: begin
          if (spec_q == istp_pkg::SPEC_CR) begin
            if (data_byte_i != istp_pkg::CH_CR) begin
              done = 1'b1; status = istp_pkg::ST_BAD_SPEC;
            end else begin
              spec_d = istp_pkg::SPEC_LF;
              if (last_i) begin done = 1'b1; status = istp_pkg::ST_BAD_SPEC; end
            end
          end else begin
            if (data_byte_i != istp_pkg::CH_LF) begin
              done = 1'b1; status = istp_pkg::ST_BAD_SPEC;
            end else if (cnt_q == '0) begin
              done = 1'b1; status = istp_pkg::ST_OK;
            end else begin
              phase_d = PH_DATA;
              if (last_i) begin done = 1'b1; status = istp_pkg::ST_NO_DATA; end
            end
          end
        end
        PH_DATA: begin
          ob    = data_byte_i;
          ov    = 1'b1;
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            done = 1'b1; status = istp_pkg::ST_OK;
          end else if (last_i) begin
            done = 1'b1; status = istp_pkg::ST_NO_DATA;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    if (done) begin
      phase_d = PH_IDLE;
      esc_d   = 1'b0;
      if (status == istp_pkg::ST_NOT_STRING) begin
        kind_d = istp_pkg::KIND_QUOTED;
      end
    end
  end

  assign res_o.out_byte  = ob;
  assign res_o.out_valid = ov;
  assign res_o.done_res  = done;
  assign res_o.kind      = kind_d;
  assign res_o.status    = status;
  assign res_valid_o     = accept_i && (ov || done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      esc_q   <= 1'b0;
      cnt_q   <= '0;
      digit_q <= 1'b0;
      spec_q  <= 2'd0;
      kind_q  <= istp_pkg::KIND_QUOTED;
    end else if (accept_i) begin
      phase_q <= phase_d;
      esc_q   <= esc_d;
      cnt_q   <= cnt_d;
      digit_q <= digit_d;
      spec_q  <= spec_d;
      kind_q  <= kind_d;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/istp_out_buf.sv
// Result register with a skid entry; the input side sees an output stall only once the skid entry is held.
// Depends on istp_pkg.
`default_nettype none
module istp_out_buf (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire istp_pkg::result_t in_data_i,
  output logic                   ready_o,
  output logic                   out_valid_o,
  output istp_pkg::result_t      out_data_o,
  input  wire logic              out_ready_i
);

  logic              main_v_q, skid_v_q;
  istp_pkg::result_t main_q, skid_q;
  logic              pop;

  assign pop         = main_v_q && out_ready_i;
  assign ready_o     = !skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (!main_v_q || pop) begin
      main_v_q <= in_valid_i;
    end else if (in_valid_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (!main_v_q || pop) begin
      if (in_valid_i) begin
        main_q <= in_data_i;
      end
    end else if (in_valid_i) begin
      skid_q <= in_data_i;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/imap_string_token_parser_top.sv
// Top level of the IMAP string token parser: parse state machine and result buffer.
// Depends on istp_pkg, istp_parse and istp_out_buf.
//
// Input stream: one line byte per item in s_axis_tdata, tuser marks the first byte
// of a string token, tlast marks the final byte of the available line data.
// Output stream: one item per payload byte or token end. tdata carries the byte,
// its valid flag and the status; tuser carries the token kind; tlast marks the end
// of a token (success or error). Bytes that produce nothing produce no item.
// Throughput: one byte per cycle while s_axis_tready_o is high. Each byte updates the
// parse state when accepted; its result is registered in the result register.
// The size accumulator is SIZE_BITS wide; larger sizes end the token with an error.
// Reset puts the parser idle and empties the output buffer.
// A stalled receiver fills the result register and then a one-item skid entry;
// s_axis_tready_o drops only while the skid entry is held.
`default_nettype none
module imap_string_token_parser_top #(
  parameter int SIZE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] first
  input  wire logic        s_axis_tlast_i,   // last
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] out_byte, [8] out_valid, [11:9] status
  output logic [1:0]       m_axis_tuser_o,   // [1:0] kind
  output logic             m_axis_tlast_o    // done_res
);

  istp_pkg::result_t res, out_res;
  logic              res_valid;
  logic              accept;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  istp_parse #(
    .SIZE_BITS(SIZE_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (s_axis_tdata_i),
    .first_i     (s_axis_tuser_i),
    .last_i      (s_axis_tlast_i),
    .res_o       (res),
    .res_valid_o (res_valid)
  );

  istp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_data_i   (res),
    .ready_o     (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {4'b0, out_res.status, out_res.out_valid, out_res.out_byte};
  assign m_axis_tuser_o = out_res.kind;
  assign m_axis_tlast_o = out_res.done_res;

endmodule
`default_nettype wire
